// File: hdl/key_press_and_wheel_classifier_defines.svh
// Assertion macros for the key press and wheel classifier.
`ifndef KEY_PRESS_AND_WHEEL_CLASSIFIER_DEFINES_SVH
`define KEY_PRESS_AND_WHEEL_CLASSIFIER_DEFINES_SVH

// Check a property while out of reset.
`define KPWC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property at every edge, reset included.
`define KPWC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: hdl/kpwc_pkg.sv
// Shared types and constants for the key press and wheel classifier.
package kpwc_pkg;

  localparam int KEY_COUNT    = 3;
  localparam int TICK_BITS    = 16;
  localparam int REPEAT_TICKS = 50;
  localparam int REP_BITS     = (REPEAT_TICKS > 1) ? $clog2(REPEAT_TICKS) : 1;

  localparam int DEBOUNCE_BITS = 10;
  localparam int LONG_BITS     = 14;
  localparam int CFG_DATA_BITS = 14;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [KEY_COUNT-1:0]     REPEAT_MASK_RESET = KEY_COUNT'(3);
  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET    = DEBOUNCE_BITS'(20);
  localparam logic [LONG_BITS-1:0]     LONG_PRESS_RESET  = LONG_BITS'(200);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_REPEAT_MASK = 2'd0,
    CFG_DEBOUNCE    = 2'd1,
    CFG_LONG_PRESS  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FILTER = 2'd1,
    PH_PRESS  = 2'd2,
    PH_LONG   = 2'd3
  } key_phase_t;

  typedef struct packed {
    logic                     rep_en;
    logic [DEBOUNCE_BITS-1:0] debounce;
    logic [LONG_BITS-1:0]     long_press;
  } key_cfg_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
  } key_evt_t;

  typedef struct packed {
    logic up;
    logic down;
  } wheel_evt_t;

endpackage

// File: hdl/kpwc_key.sv
// Per-key phase machine with tick counter and repeat residue.
module kpwc_key (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               pressed,
  input  kpwc_pkg::key_cfg_t cfg,
  output kpwc_pkg::key_evt_t evt
);
  import kpwc_pkg::*;

  key_phase_t           phase;
  key_phase_t           phase_next;
  logic [TICK_BITS-1:0] ticks;
  logic [TICK_BITS-1:0] ticks_next;
  logic [REP_BITS-1:0]  residue;
  logic [REP_BITS-1:0]  residue_next;
  logic [TICK_BITS-1:0] ticks_bump;
  logic [REP_BITS-1:0]  residue_bump;

  always_comb begin
    ticks_bump = TICK_BITS'(ticks + 1'b1);
    if (ticks == '1 || residue == REP_BITS'(REPEAT_TICKS - 1)) begin
      residue_bump = '0;
    end else begin
      residue_bump = REP_BITS'(residue + 1'b1);
    end
  end

  always_comb begin
    ticks_next   = ticks;
    residue_next = residue;
    if (phase == PH_IDLE) begin
      if (!pressed) begin
        ticks_next   = '0;
        residue_next = '0;
      end
    end else if (pressed) begin
      ticks_next   = ticks_bump;
      residue_next = residue_bump;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (pressed) phase_next = PH_FILTER;
      end
      PH_FILTER: begin
        if (!pressed) phase_next = PH_IDLE;
        if (ticks_next >= TICK_BITS'(cfg.debounce)) phase_next = PH_PRESS;
      end
      PH_PRESS: begin
        if (!pressed) phase_next = PH_IDLE;
        if (ticks_next > TICK_BITS'(cfg.long_press)) phase_next = PH_LONG;
      end
      PH_LONG: begin
        if (!pressed) phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    evt = '0;
    unique case (phase)
      PH_IDLE, PH_FILTER: evt = '0;
      PH_PRESS: begin
        evt.short_press = !pressed;
        evt.long_press  = ticks_next > TICK_BITS'(cfg.long_press);
      end
      PH_LONG: begin
        evt.long_press = cfg.rep_en && (residue_next == '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      ticks   <= '0;
      residue <= '0;
    end else if (advance) begin
      phase   <= phase_next;
      ticks   <= ticks_next;
      residue <= residue_next;
    end
  end

endmodule

// File: hdl/kpwc_wheel.sv
// Wheel step decoder: arm on pin A low, report on pin A high.
module kpwc_wheel (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 pin_a,
  input  logic                 pin_b,
  output kpwc_pkg::wheel_evt_t evt
);
  import kpwc_pkg::*;

  logic armed;
  logic armed_next;

  always_comb begin
    armed_next = armed;
    evt        = '0;
    if (!armed) begin
      if (!pin_a) armed_next = 1'b1;
    end else if (pin_a) begin
      evt.up     = !pin_b;
      evt.down   = pin_b;
      armed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
    end else if (advance) begin
      armed <= armed_next;
    end
  end

endmodule

// File: hdl/key_press_and_wheel_classifier.sv
// Each accepted word yields its result word at the output register in the next cycle.
// Throughput: one word per cycle while the output is not stalled; the per-key and wheel logic is a single pass.
// in_ready drops only while a result word is held and out_ready is low.
// Reset clears key phases, counters, wheel arming and the result valid flag,
// and loads the configuration registers with their default values.
module key_press_and_wheel_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kpwc_pkg::KEY_COUNT-1:0] key_levels,
  input  logic                          wheel_a,
  input  logic                          wheel_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kpwc_pkg::KEY_COUNT-1:0] short_press_mask,
  output logic [kpwc_pkg::KEY_COUNT-1:0] long_press_mask,
  output logic                          wheel_up,
  output logic                          wheel_down,
  input  logic                          cfg_we,
  input  logic [kpwc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [kpwc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import kpwc_pkg::*;

  logic [KEY_COUNT-1:0]     repeat_enable_mask;
  logic [DEBOUNCE_BITS-1:0] debounce_ticks;
  logic [LONG_BITS-1:0]     long_press_ticks;
  logic                     advance;
  logic [KEY_COUNT-1:0]     short_evt;
  logic [KEY_COUNT-1:0]     long_evt;
  wheel_evt_t               wheel_evt;

  assign in_ready = !out_valid || out_ready;
  assign advance  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_enable_mask <= REPEAT_MASK_RESET;
      debounce_ticks     <= DEBOUNCE_RESET;
      long_press_ticks   <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPEAT_MASK: repeat_enable_mask <= cfg_data[KEY_COUNT-1:0];
        CFG_DEBOUNCE:    debounce_ticks     <= cfg_data[DEBOUNCE_BITS-1:0];
        CFG_LONG_PRESS:  long_press_ticks   <= cfg_data[LONG_BITS-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < KEY_COUNT; i++) begin : g_key
    key_cfg_t kcfg;
    key_evt_t kevt;

    assign kcfg.rep_en     = repeat_enable_mask[i];
    assign kcfg.debounce   = debounce_ticks;
    assign kcfg.long_press = long_press_ticks;

    kpwc_key u_key (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .pressed (!key_levels[i]),
      .cfg     (kcfg),
      .evt     (kevt)
    );

    assign short_evt[i] = kevt.short_press;
    assign long_evt[i]  = kevt.long_press;
  end

  kpwc_wheel u_wheel (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .pin_a   (wheel_a),
    .pin_b   (wheel_b),
    .evt     (wheel_evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      short_press_mask <= short_evt;
      long_press_mask  <= long_evt;
      wheel_up         <= wheel_evt.up;
      wheel_down       <= wheel_evt.down;
    end
  end

endmodule

// File: hdl/kpwc_checker.sv
// Port-level checks for the key press and wheel classifier, with bind.
`include "key_press_and_wheel_classifier_defines.svh"

module kpwc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [kpwc_pkg::KEY_COUNT-1:0] short_press_mask,
  input logic [kpwc_pkg::KEY_COUNT-1:0] long_press_mask,
  input logic                           wheel_up,
  input logic                           wheel_down
);
  import kpwc_pkg::*;

  logic [2*KEY_COUNT+1:0] out_word;

  assign out_word = {short_press_mask, long_press_mask, wheel_up, wheel_down};

  `KPWC_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_word))
  `KPWC_ASSERT(a_stall_blocks_in, clk, rst, out_valid && !out_ready |-> !in_ready)
  `KPWC_ASSERT(a_accept_gives_word, clk, rst, in_valid && in_ready |=> out_valid)
  `KPWC_ASSERT(a_wheel_one_dir, clk, rst, out_valid |-> !(wheel_up && wheel_down))
  `KPWC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid)

endmodule

bind key_press_and_wheel_classifier kpwc_checker u_kpwc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .short_press_mask (short_press_mask),
  .long_press_mask  (long_press_mask),
  .wheel_up         (wheel_up),
  .wheel_down       (wheel_down)
);

// File: sim/tb_top.sv
// Testbench for the key press and wheel classifier: scan-tick stimulus, prediction and checking.
`timescale 1ns / 100ps

module tb_top;
  import kpwc_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [KEY_COUNT-1:0] short_m;
    logic [KEY_COUNT-1:0] long_m;
    logic                 up;
    logic                 down;
  } tick_events_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN} rx_mode_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [KEY_COUNT-1:0]     key_levels;
  logic                     wheel_a;
  logic                     wheel_b;
  logic                     out_valid;
  logic                     out_ready;
  logic [KEY_COUNT-1:0]     short_press_mask;
  logic [KEY_COUNT-1:0]     long_press_mask;
  logic                     wheel_up;
  logic                     wheel_down;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  key_phase_t               kphase [KEY_COUNT];
  logic [TICK_BITS-1:0]     kcount [KEY_COUNT];
  logic                     armed = 1'b0;
  logic [KEY_COUNT-1:0]     cfg_rep_mask = REPEAT_MASK_RESET;
  logic [DEBOUNCE_BITS-1:0] cfg_debounce = DEBOUNCE_RESET;
  logic [LONG_BITS-1:0]     cfg_long = LONG_PRESS_RESET;

  tick_events_t pending_events[$];
  int           err_count = 0;
  int           burst_left = 0;

  logic [KEY_COUNT-1:0] key_up = '1;
  int                   run_left [KEY_COUNT];
  logic [1:0]           wpos = 2'd0;
  logic                 wdir = 1'b0;

  key_press_and_wheel_classifier i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .key_levels       (key_levels),
    .wheel_a          (wheel_a),
    .wheel_b          (wheel_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .short_press_mask (short_press_mask),
    .long_press_mask  (long_press_mask),
    .wheel_up         (wheel_up),
    .wheel_down       (wheel_down),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic tick_events_t classify_tick(logic [KEY_COUNT-1:0] lv, logic a, logic b);
    tick_events_t ev;
    logic         pressed;
    ev = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      pressed = !lv[k];
      case (kphase[k])
        PH_IDLE: begin
          if (pressed) kphase[k] = PH_FILTER;
          else kcount[k] = '0;
        end
        PH_FILTER: begin
          if (pressed) kcount[k] = kcount[k] + 1'b1;
          else kphase[k] = PH_IDLE;
          if (kcount[k] >= cfg_debounce) kphase[k] = PH_PRESS;
        end
        PH_PRESS: begin
          if (pressed) begin
            kcount[k] = kcount[k] + 1'b1;
          end else begin
            ev.short_m[k] = 1'b1;
            kphase[k] = PH_IDLE;
          end
          if (kcount[k] > cfg_long) begin
            ev.long_m[k] = 1'b1;
            kphase[k] = PH_LONG;
          end
        end
        default: begin
          if (pressed) kcount[k] = kcount[k] + 1'b1;
          else kphase[k] = PH_IDLE;
          if (cfg_rep_mask[k] && (kcount[k] % REPEAT_TICKS) == 0) ev.long_m[k] = 1'b1;
        end
      endcase
    end
    if (!armed) begin
      if (!a) armed = 1'b1;
    end else if (a) begin
      if (!b) ev.up = 1'b1;
      else ev.down = 1'b1;
      armed = 1'b0;
    end
    return ev;
  endfunction

  task automatic scan_tick(logic [KEY_COUNT-1:0] lv, logic a, logic b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                   $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    key_levels <= lv;
    wheel_a    <= a;
    wheel_b    <= b;
    do @(posedge clk); while (!in_ready);
    pending_events.push_back(classify_tick(lv, a, b));
  endtask

  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_BITS'(val);
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      CFG_REPEAT_MASK: cfg_rep_mask = KEY_COUNT'(val);
      CFG_DEBOUNCE:    cfg_debounce = DEBOUNCE_BITS'(val);
      default:         cfg_long = LONG_BITS'(val);
    endcase
  endtask

  task automatic load_settings(int unsigned mask, int unsigned deb, int unsigned lng);
    wait_drained();
    write_reg(CFG_REPEAT_MASK, mask);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_LONG_PRESS, lng);
  endtask

  function automatic logic [KEY_COUNT-1:0] next_levels();
    int span;
    span = int'(cfg_debounce) + int'(cfg_long) + 2 * REPEAT_TICKS + 10;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (run_left[k] <= 0) begin
        key_up[k] = !key_up[k];
        if (key_up[k]) run_left[k] = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) :
                                     $urandom_range(1, 6);
        else if ($urandom_range(0, 3) == 0) run_left[k] = $urandom_range(1, 3);
        else run_left[k] = $urandom_range(1, span);
      end
      run_left[k]--;
    end
    return ($urandom_range(0, 19) == 0) ? KEY_COUNT'($urandom_range(0, 7)) : key_up;
  endfunction

  function automatic logic [1:0] next_wheel();
    if ($urandom_range(0, 9) == 0) return 2'($urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0) wdir = !wdir;
    if ($urandom_range(0, 1) == 1) wpos = wdir ? wpos + 2'd1 : wpos - 2'd1;
    return {wpos[1], wpos[1] ^ wpos[0]};
  endfunction

  task automatic run_scan(int n);
    logic [1:0] w;
    for (int i = 0; i < n; i++) begin
      w = next_wheel();
      scan_tick(next_levels(), w[1], w[0]);
    end
  endtask

  task automatic hold_keys(logic [KEY_COUNT-1:0] lv, int n);
    logic [1:0] w;
    for (int i = 0; i < n; i++) begin
      w = next_wheel();
      scan_tick(lv, w[1], w[0]);
    end
  endtask

  task automatic test_reset_config();
    run_scan(150);
  endtask

  task automatic test_edge_cases();
    load_settings(7, 0, 1);
    hold_keys('1, 4);
    scan_tick(3'b111, 1'b1, 1'b1);
    scan_tick(3'b110, 1'b0, 1'b0);
    scan_tick(3'b111, 1'b1, 1'b0);
    scan_tick(3'b111, 1'b0, 1'b1);
    scan_tick(3'b111, 1'b1, 1'b1);
    scan_tick(3'b000, 1'b1, 1'b1);
    scan_tick(3'b000, 1'b0, 1'b0);
    scan_tick(3'b000, 1'b0, 1'b1);
    scan_tick(3'b000, 1'b1, 1'b1);
    scan_tick(3'b111, 1'b1, 1'b0);
    scan_tick(3'b000, 1'b0, 1'b0);
    scan_tick(3'b111, 1'b1, 1'b1);
    scan_tick(3'b111, 1'b0, 1'b1);
    scan_tick(3'b111, 1'b1, 1'b0);
    scan_tick(3'b111, 1'b1, 1'b1);
    load_settings(7, 1, 0);
    scan_tick(3'b010, 1'b0, 1'b0);
    scan_tick(3'b010, 1'b1, 1'b1);
    scan_tick(3'b000, 1'b1, 1'b0);
    scan_tick(3'b111, 1'b0, 1'b1);
    scan_tick(3'b111, 1'b1, 1'b0);
  endtask

  task automatic test_repeat_events();
    load_settings(3'b101, 1, 2);
    hold_keys('1, 4);
    hold_keys('0, 101);
    hold_keys('1, 3);
    load_settings(0, 1, 2);
    hold_keys('0, 120);
    hold_keys('1, 3);
  endtask

  task automatic test_random_configs();
    int unsigned deb;
    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 3))
        0:       deb = 0;
        1:       deb = 1;
        default: deb = $urandom_range(2, 12);
      endcase
      load_settings($urandom_range(0, 7), deb, $urandom_range(0, 40));
      run_scan(90);
    end
  endtask

  task automatic test_counter_extremes();
    load_settings(7, 1000, 10000);
    hold_keys('1, 3);
    hold_keys('0, 20);
    hold_keys('1, 3);
    load_settings(7, 1023, 16383);
    hold_keys('1, 3);
    hold_keys(3'b100, 30);
    hold_keys('1, 2);
    hold_keys(3'b000, 3);
    hold_keys('1, 4);
  endtask

  initial begin
    rx_mode_t   mode;
    int         mode_left;
    logic [7:0] pattern;
    int         pat_bit;
    mode_left = 0;
    pat_bit   = 0;
    out_ready = 1'b0;
    forever begin
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
        pattern   = 8'($urandom) | 8'd1;
      end
      mode_left--;
      @(negedge clk);
      case (mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ready <= pattern[pat_bit];
          pat_bit = (pat_bit + 1) % 8;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    tick_events_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: short=%b long=%b up=%b down=%b",
                   short_press_mask, long_press_mask, wheel_up, wheel_down);
      end else begin
        want = pending_events.pop_front();
        if (short_press_mask !== want.short_m || long_press_mask !== want.long_m ||
            wheel_up !== want.up || wheel_down !== want.down) begin
          err_count++;
          if (err_count <= 10)
            $display({"mismatch: exp short=%b long=%b up=%b down=%b, ",
                      "got short=%b long=%b up=%b down=%b"},
                     want.short_m, want.long_m, want.up, want.down,
                     short_press_mask, long_press_mask, wheel_up, wheel_down);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    key_levels = '1;
    wheel_a    = 1'b1;
    wheel_b    = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = CFG_REPEAT_MASK;
    cfg_data   = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      kphase[k]   = PH_IDLE;
      kcount[k]   = '0;
      run_left[k] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_reset_config();
    test_edge_cases();
    test_repeat_events();
    test_random_configs();
    test_counter_extremes();

    wait_drained();
    repeat (4) @(posedge clk);
    if (err_count == 0 && pending_events.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/kpwc_pkg.sv
hdl/kpwc_key.sv
hdl/kpwc_wheel.sv
hdl/key_press_and_wheel_classifier.sv
hdl/kpwc_checker.sv
sim/tb_top.sv
